/* rtl/core/i2cmm_pkg.sv */
// shared types and constants for the i2c master with mux routing
package i2cmm_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_BEGIN = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_STOP  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SDA_STUCK = 3'd1,
        ST_SCL_STUCK = 3'd2,
        ST_ADDR_NACK = 3'd3,
        ST_DATA_NACK = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_PREP, PH_REC_IDLE, PH_REC_LOW, PH_REC_HIGH, PH_REC_SDALOW,
        PH_REC_SCLREL, PH_REC_SDAREL, PH_START1, PH_START2, PH_TX_A, PH_TX_B,
        PH_TX_C, PH_ACK_A, PH_ACK_B, PH_ACK_OK, PH_STOP_AL, PH_STOP_A,
        PH_STOP_B, PH_STOP_C, PH_RX_A, PH_RX_B, PH_RXACK_A, PH_RXACK_B,
        PH_DONE, PH_DONE_HOLD
    } phase_t;

    typedef enum logic [2:0] {
        G_PROBE   = 3'd0,
        G_MUXADDR = 3'd1,
        G_MUXDATA = 3'd2,
        G_TARGET  = 3'd3,
        G_WRITE   = 3'd4,
        G_READ    = 3'd5,
        G_STOP    = 3'd6
    } stage_t;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUX_ADDR = 1'b1;
    localparam logic [9:0] ACK_TIMEOUT_RESET = 10'd250;
    localparam logic [6:0] MUX_ADDR_RESET = 7'h70;

    // classified request passed from front to back
    typedef struct packed {
        op_t        op;
        logic       sda_level;
        logic       use_direct;
        logic [3:0] channel;
        logic [6:0] device_address;
        logic       read_not_write;
        logic [7:0] data_byte;
        logic       ack_after_read;
    } req_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       ready_res;
        logic       op_done;
        logic [7:0] read_byte;
        status_t    status;
        logic       mux_found;
    } res_t;

endpackage

/* rtl/core/i2cmm_fifo.sv */
// small request queue between the front and the sequencer
module i2cmm_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_data;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* rtl/core/i2cmm_seq.sv */
// bus sequencer: runs one request per cycle while no pending result is held off by res_ready, and registers the result
module i2cmm_seq #(
    parameter int MUX_CHANNELS    = 8,
    parameter int RECOVERY_CLOCKS = 9
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [9:0]        cfg_data,
    input  logic              req_valid,
    output logic              req_ready,
    input  i2cmm_pkg::req_t   req,
    output logic              res_valid,
    input  logic              res_ready,
    output i2cmm_pkg::res_t   res
);
    import i2cmm_pkg::*;

    phase_t     phase_reg, phase_next;
    stage_t     stage_reg, stage_next;
    logic [3:0] bitc_reg, bitc_next;
    logic [7:0] shift_reg, shift_next;
    logic [9:0] wait_reg, wait_next;
    status_t    last_reg, last_next;
    status_t    sbp_reg, sbp_next;
    logic [7:0] pend_reg, pend_next;
    logic       scl_reg, scl_next, sda_reg, sda_next;
    logic [7:0] mask_reg, mask_next;
    logic       direct_reg, direct_next;
    logic       found_reg, found_next;
    logic       ackl_reg, ackl_next;
    logic       nack_reg, nack_next;
    logic [9:0] tmo_reg;
    logic [6:0] muxa_reg;
    logic       done;
    logic       res_v_reg;
    res_t       res_reg;
    logic       fire;
    logic [3:0] bitc_inc;

    assign req_ready = !res_v_reg || res_ready;
    assign fire      = req_valid && req_ready;
    assign res_valid = res_v_reg;
    assign res       = res_reg;
    assign bitc_inc  = bitc_reg + 4'd1;

    always_comb begin
        phase_next = phase_reg; stage_next = stage_reg; bitc_next = bitc_reg;
        shift_next = shift_reg; wait_next = wait_reg; last_next = last_reg;
        sbp_next = sbp_reg; pend_next = pend_reg; scl_next = scl_reg;
        sda_next = sda_reg; mask_next = mask_reg; direct_next = direct_reg;
        found_next = found_reg; ackl_next = ackl_reg; nack_next = nack_reg;
        done = 1'b0;
        if (phase_reg == PH_IDLE) begin
            case (req.op)
                OP_BEGIN: begin
                    pend_next   = {req.device_address, req.read_not_write};
                    direct_next = req.use_direct;
                    if (!req.use_direct && (32'(req.channel) >= MUX_CHANNELS)) begin
                        stage_next = G_TARGET;
                        last_next  = ST_ADDR_NACK;
                        phase_next = PH_DONE;
                    end else begin
                        mask_next  = req.use_direct ? 8'd0 : (8'd1 << req.channel[2:0]);
                        sbp_next   = last_reg;
                        stage_next = G_PROBE;
                        phase_next = PH_PREP;
                    end
                end
                OP_WRITE: begin
                    stage_next = G_WRITE; shift_next = req.data_byte;
                    bitc_next = 4'd0; phase_next = PH_TX_A;
                end
                OP_READ: begin
                    stage_next = G_READ; ackl_next = req.ack_after_read;
                    shift_next = 8'd0; bitc_next = 4'd0; phase_next = PH_RX_A;
                end
                OP_STOP: begin
                    stage_next = G_STOP; nack_next = 1'b0; phase_next = PH_STOP_A;
                end
                default: ;
            endcase
        end else if (req.op == OP_TICK) begin
            case (phase_reg)
                PH_PREP: begin
                    last_next = ST_OK; nack_next = 1'b0; scl_next = 1'b0; sda_next = 1'b0;
                    phase_next = req.sda_level ? PH_START1 : PH_REC_IDLE;
                end
                PH_REC_IDLE: begin
                    scl_next = 1'b0; sda_next = 1'b0; bitc_next = 4'd0;
                    phase_next = PH_REC_LOW;
                end
                PH_REC_LOW: begin
                    scl_next = 1'b1; sda_next = 1'b0; phase_next = PH_REC_HIGH;
                end
                PH_REC_HIGH: begin
                    scl_next = 1'b0; sda_next = 1'b0; bitc_next = bitc_inc;
                    phase_next = (32'(bitc_inc) >= RECOVERY_CLOCKS) ? PH_REC_SDALOW
                                                                     : PH_REC_LOW;
                end
                PH_REC_SDALOW: begin
                    scl_next = 1'b0; sda_next = 1'b1; phase_next = PH_REC_SCLREL;
                end
                PH_REC_SCLREL: begin
                    scl_next = 1'b0; sda_next = 1'b1; phase_next = PH_REC_SDAREL;
                end
                PH_REC_SDAREL: begin
                    scl_next = 1'b0; sda_next = 1'b0;
                    if (nack_reg) begin
                        phase_next = PH_STOP_A;
                    end else if (req.sda_level) begin
                        phase_next = PH_START1;
                    end else begin
                        last_next = ST_SDA_STUCK;
                        if (stage_reg == G_PROBE) begin
                            // probe failed on a stuck bus
                            found_next = 1'b0;
                            if (direct_reg) begin
                                stage_next = G_TARGET; phase_next = PH_PREP;
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_START1: begin
                    scl_next = 1'b0; sda_next = 1'b0; phase_next = PH_START2;
                end
                PH_START2: begin
                    scl_next = 1'b0; sda_next = 1'b1;
                    shift_next = (stage_reg == G_TARGET) ? pend_reg : {muxa_reg, 1'b0};
                    bitc_next = 4'd0; phase_next = PH_TX_A;
                end
                PH_TX_A: begin
                    scl_next = 1'b1; phase_next = PH_TX_B;
                end
                PH_TX_B: begin
                    scl_next = 1'b1; sda_next = ~shift_reg[7]; phase_next = PH_TX_C;
                end
                PH_TX_C: begin
                    scl_next = 1'b0; shift_next = {shift_reg[6:0], 1'b0};
                    bitc_next = bitc_inc;
                    phase_next = (bitc_inc >= 4'd8) ? PH_ACK_A : PH_TX_A;
                end
                PH_ACK_A: begin
                    scl_next = 1'b1; sda_next = 1'b0; wait_next = 10'd0;
                    phase_next = PH_ACK_B;
                end
                PH_ACK_B: begin
                    scl_next = 1'b0; sda_next = 1'b0;
                    if (!req.sda_level) begin
                        phase_next = PH_ACK_OK;
                    end else if (wait_reg >= tmo_reg) begin
                        nack_next = 1'b1; phase_next = PH_REC_IDLE;
                    end else begin
                        wait_next = wait_reg + 10'd1;
                    end
                end
                PH_ACK_OK: begin
                    scl_next = 1'b0; sda_next = 1'b0;
                    if (stage_reg == G_PROBE || stage_reg == G_MUXDATA) begin
                        phase_next = PH_STOP_AL;
                    end else if (stage_reg == G_MUXADDR) begin
                        shift_next = mask_reg; bitc_next = 4'd0;
                        stage_next = G_MUXDATA; phase_next = PH_TX_A;
                    end else begin
                        phase_next = PH_DONE_HOLD;
                    end
                end
                PH_STOP_AL: begin
                    scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_STOP_B;
                end
                PH_STOP_A: begin
                    sda_next = 1'b1; phase_next = PH_STOP_B;
                end
                PH_STOP_B: begin
                    scl_next = 1'b0; sda_next = 1'b1; phase_next = PH_STOP_C;
                end
                PH_STOP_C: begin
                    scl_next = 1'b0; sda_next = 1'b0;
                    if (nack_reg) begin
                        nack_next = 1'b0;
                        if (stage_reg == G_PROBE) begin
                            found_next = 1'b0;
                            if (direct_reg) begin
                                last_next = sbp_reg;
                                stage_next = G_TARGET; phase_next = PH_PREP;
                            end else begin
                                last_next = (sbp_reg == ST_OK) ? ST_ADDR_NACK : sbp_reg;
                                phase_next = PH_DONE;
                            end
                        end else begin
                            last_next = (stage_reg == G_MUXDATA || stage_reg == G_WRITE)
                                        ? ST_DATA_NACK : ST_ADDR_NACK;
                            phase_next = PH_DONE;
                        end
                    end else if (stage_reg == G_PROBE) begin
                        found_next = 1'b1; last_next = ST_OK;
                        stage_next = G_MUXADDR; phase_next = PH_PREP;
                    end else if (stage_reg == G_MUXDATA) begin
                        stage_next = G_TARGET; phase_next = PH_PREP;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_RX_A: begin
                    scl_next = 1'b1; sda_next = 1'b0; phase_next = PH_RX_B;
                end
                PH_RX_B: begin
                    scl_next = 1'b0; sda_next = 1'b0;
                    shift_next = {shift_reg[6:0], req.sda_level};
                    bitc_next = bitc_inc;
                    phase_next = (bitc_inc >= 4'd8) ? PH_RXACK_A : PH_RX_A;
                end
                PH_RXACK_A: begin
                    scl_next = 1'b1; sda_next = ackl_reg; phase_next = PH_RXACK_B;
                end
                PH_RXACK_B: begin
                    scl_next = 1'b0; sda_next = ackl_reg; phase_next = PH_DONE_HOLD;
                end
                PH_DONE_HOLD: begin
                    scl_next = 1'b1; sda_next = 1'b0; done = 1'b1; phase_next = PH_IDLE;
                end
                PH_DONE: begin
                    done = 1'b1; phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; stage_reg <= G_PROBE; bitc_reg <= 4'd0;
            shift_reg <= 8'd0; wait_reg <= 10'd0; last_reg <= ST_OK; sbp_reg <= ST_OK;
            pend_reg <= 8'd0; scl_reg <= 1'b0; sda_reg <= 1'b0; mask_reg <= 8'd0;
            direct_reg <= 1'b0; found_reg <= 1'b0; ackl_reg <= 1'b0; nack_reg <= 1'b0;
            tmo_reg <= ACK_TIMEOUT_RESET; muxa_reg <= MUX_ADDR_RESET;
            res_v_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ACK_TIMEOUT: tmo_reg  <= cfg_data;
                    CFG_MUX_ADDR:    muxa_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (fire) begin
                phase_reg <= phase_next; stage_reg <= stage_next; bitc_reg <= bitc_next;
                shift_reg <= shift_next; wait_reg <= wait_next; last_reg <= last_next;
                sbp_reg <= sbp_next; pend_reg <= pend_next; scl_reg <= scl_next;
                sda_reg <= sda_next; mask_reg <= mask_next; direct_reg <= direct_next;
                found_reg <= found_next; ackl_reg <= ackl_next; nack_reg <= nack_next;
                res_v_reg <= 1'b1;
            end else if (res_ready) begin
                res_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg.scl_low   <= scl_next;
            res_reg.sda_low   <= sda_next;
            res_reg.ready_res <= (phase_next == PH_IDLE);
            res_reg.op_done   <= done;
            res_reg.read_byte <= (done && stage_next == G_READ) ? shift_next : 8'd0;
            res_reg.status    <= last_next;
            res_reg.mux_found <= found_next;
        end
    end
endmodule

/* rtl/core/i2c_master_with_mux_routing_top.sv */
// top level: i2c master with mux routing
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid/s_ready   | op, sda_level, begin and byte fields
//  m_      | out       | m_valid/m_ready   | line drives, ready, done, byte, status
//  cfg     | in        | cfg_we            | cfg_index, cfg_data
// one request per cycle unless m_ stalls; path is queue, then sequencer register
// each tick advances the sequencer by one half-bit phase
// aresetn is synchronous and active low, control registers return to reset values
// a stalled m_ side fills the two-entry queue, then s_ready drops
module i2c_master_with_mux_routing_top #(
    parameter int MUX_CHANNELS    = 8,
    parameter int RECOVERY_CLOCKS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic        s_sda_level,
    input  logic        s_use_direct,
    input  logic [3:0]  s_channel,
    input  logic [6:0]  s_device_address,
    input  logic        s_read_not_write,
    input  logic [7:0]  s_data_byte,
    input  logic        s_ack_after_read,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_low,
    output logic        m_sda_low,
    output logic        m_ready_res,
    output logic        m_op_done,
    output logic [7:0]  m_read_byte,
    output logic [2:0]  m_status,
    output logic        m_mux_found
);
    import i2cmm_pkg::*;

    req_t in_req, q_req;
    res_t r;
    logic q_valid, q_ready;
    logic [$bits(req_t)-1:0] q_data;

    // classify: unknown op codes are kept raw and leave the sequencer state unchanged
    always_comb begin
        in_req.op             = op_t'(s_op);
        in_req.sda_level      = s_sda_level;
        in_req.use_direct     = s_use_direct;
        in_req.channel        = s_channel;
        in_req.device_address = s_device_address;
        in_req.read_not_write = s_read_not_write;
        in_req.data_byte      = s_data_byte;
        in_req.ack_after_read = s_ack_after_read;
    end

    i2cmm_fifo #(.WIDTH($bits(req_t))) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(in_req),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    assign q_req = req_t'(q_data);

    i2cmm_seq #(.MUX_CHANNELS(MUX_CHANNELS), .RECOVERY_CLOCKS(RECOVERY_CLOCKS)) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .res_valid(m_valid), .res_ready(m_ready), .res(r)
    );

    assign m_scl_low   = r.scl_low;
    assign m_sda_low   = r.sda_low;
    assign m_ready_res = r.ready_res;
    assign m_op_done   = r.op_done;
    assign m_read_byte = r.read_byte;
    assign m_status    = r.status;
    assign m_mux_found = r.mux_found;
endmodule
